// ===== sv/tecc_pkg.sv =====
// shared types and constants for the two-electron coulomb coefficient core
package tecc_pkg;

  localparam int COORD_W = 16;
  localparam int D2_W    = 34;
  localparam int Q_W     = 33;
  localparam int COEF_W  = 34;
  localparam int CFG_W   = 41;
  localparam int IDX_W   = 3;

  localparam int DIV_STAGES  = 65;
  localparam int SQRT_STAGES = 33;
  localparam int DIST_STAGES = 2;
  localparam int COMB_STAGES = 5;
  localparam int LATENCY     = DIST_STAGES + DIV_STAGES + SQRT_STAGES + COMB_STAGES;

  localparam logic [Q_W-1:0] RECIP_CAP = 33'd6553600000;

  typedef enum logic [IDX_W-1:0] {
    REG_ELECTRON_COUNT  = 3'd0,
    REG_SCALE_FACTOR    = 3'd1,
    REG_SHIFT_ENABLE    = 3'd2,
    REG_SHIFT_OFFSET    = 3'd3,
    REG_COUPLING_WEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         electron_count;
    logic [15:0]        scale_factor;
    logic               shift_enable;
    logic signed [40:0] shift_offset;
    logic [16:0]        coupling_weight;
  } cfg_t;

endpackage

// ===== sv/tecc_if.sv =====
// valid/ready channel interfaces for sample points and coefficients
interface tecc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] e0_x;
  logic [15:0] e0_y;
  logic [15:0] e0_z;
  logic [15:0] e1_x;
  logic [15:0] e1_y;
  logic [15:0] e1_z;
  modport source (output valid, e0_x, e0_y, e0_z, e1_x, e1_y, e1_z, input ready);
  modport sink (input valid, e0_x, e0_y, e0_z, e1_x, e1_y, e1_z, output ready);
endinterface

interface tecc_out_if;
  logic               valid;
  logic               ready;
  logic signed [33:0] coefficient;
  modport source (output valid, coefficient, input ready);
  modport sink (input valid, coefficient, output ready);
endinterface

// ===== sv/tecc_sqdist.sv =====
// squared distances of both electrons from the centre and from each other
module tecc_sqdist (
  input  logic                      clk,
  input  logic                      en,
  input  logic [15:0]               e0_x,
  input  logic [15:0]               e0_y,
  input  logic [15:0]               e0_z,
  input  logic [15:0]               e1_x,
  input  logic [15:0]               e1_y,
  input  logic [15:0]               e1_z,
  output logic [tecc_pkg::D2_W-1:0] d2_a,
  output logic [tecc_pkg::D2_W-1:0] d2_b,
  output logic [tecc_pkg::D2_W-1:0] d2_r
);
  import tecc_pkg::*;

  logic [15:0] crd [6];
  logic [32:0] sqc_nxt [6];
  logic [32:0] sqc_r [6];
  logic [31:0] sqr_nxt [3];
  logic [31:0] sqr_r [3];
  logic [D2_W-1:0] d2a_r, d2b_r, d2r_r;

  assign crd[0] = e0_x;
  assign crd[1] = e0_y;
  assign crd[2] = e0_z;
  assign crd[3] = e1_x;
  assign crd[4] = e1_y;
  assign crd[5] = e1_z;

  // mapped coordinate 2c-1 as integer distance from 65536
  always_comb begin
    logic [16:0] dc;
    logic [15:0] dr;
    for (int i = 0; i < 6; i++) begin
      if (crd[i][15]) begin
        dc = {crd[i], 1'b0} - 17'h10000;
      end else begin
        dc = 17'h10000 - {crd[i], 1'b0};
      end
      sqc_nxt[i] = 33'(dc) * 33'(dc);
    end
    for (int i = 0; i < 3; i++) begin
      dr = (crd[i] >= crd[i+3]) ? crd[i] - crd[i+3] : crd[i+3] - crd[i];
      sqr_nxt[i] = dr * dr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqc_r <= sqc_nxt;
      sqr_r <= sqr_nxt;
      d2a_r <= D2_W'(sqc_r[0]) + D2_W'(sqc_r[1]) + D2_W'(sqc_r[2]);
      d2b_r <= D2_W'(sqc_r[3]) + D2_W'(sqc_r[4]) + D2_W'(sqc_r[5]);
      d2r_r <= D2_W'(sqr_r[0]) + D2_W'(sqr_r[1]) + D2_W'(sqr_r[2]);
    end
  end

  assign d2_a = d2a_r;
  assign d2_b = d2b_r;
  assign d2_r = d2r_r;
endmodule

// ===== sv/tecc_recip.sv =====
// pipelined capped reciprocal square root: divide then square root, one bit a stage
module tecc_recip (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tecc_pkg::D2_W-1:0] d2,
  output logic [tecc_pkg::Q_W-1:0]  q
);
  import tecc_pkg::*;

  localparam int DS = DIV_STAGES;
  localparam int SS = SQRT_STAGES;

  logic [D2_W-1:0] dv_r  [DS];
  logic [D2_W-1:0] rem_r [DS];
  logic [64:0]     quo_r [DS];
  logic            zd_r  [DS];

  logic [65:0]     nsh_r  [SS];
  logic [35:0]     srem_r [SS];
  logic [Q_W-1:0]  root_r [SS];
  logic            zs_r   [SS];

  // long division of 2^64 by d2
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [D2_W-1:0] dv_in, rem_in;
    logic [64:0]     quo_in;
    logic            z_in;
    logic [D2_W:0]   shf;
    logic            ge;
    if (k == 0) begin : g_first
      assign dv_in  = d2;
      assign rem_in = '0;
      assign quo_in = '0;
      assign z_in   = (d2 == '0);
      assign shf    = {rem_in, 1'b1};
    end else begin : g_next
      assign dv_in  = dv_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign z_in   = zd_r[k-1];
      assign shf    = {rem_in, 1'b0};
    end
    assign ge = (shf >= {1'b0, dv_in});
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k]  <= dv_in;
        rem_r[k] <= ge ? D2_W'(shf - {1'b0, dv_in}) : D2_W'(shf);
        quo_r[k] <= {quo_in[63:0], ge};
        zd_r[k]  <= z_in;
      end
    end
  end

  // integer square root of the quotient, two radicand bits a stage
  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    logic [65:0]    n_in;
    logic [35:0]    r_in;
    logic [Q_W-1:0] rt_in;
    logic           z_in;
    logic [35:0]    rsh;
    logic [35:0]    trial;
    logic           ge;
    if (j == 0) begin : g_first
      assign n_in  = {1'b0, quo_r[DS-1]};
      assign r_in  = '0;
      assign rt_in = '0;
      assign z_in  = zd_r[DS-1];
    end else begin : g_next
      assign n_in  = nsh_r[j-1];
      assign r_in  = srem_r[j-1];
      assign rt_in = root_r[j-1];
      assign z_in  = zs_r[j-1];
    end
    assign rsh   = {r_in[33:0], n_in[65:64]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign ge    = (rsh >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        nsh_r[j]  <= {n_in[63:0], 2'b00};
        srem_r[j] <= ge ? rsh - trial : rsh;
        root_r[j] <= {rt_in[Q_W-2:0], ge};
        zs_r[j]   <= z_in;
      end
    end
  end

  assign q = zs_r[SS-1] ? RECIP_CAP : root_r[SS-1];
endmodule

// ===== sv/tecc_combine.sv =====
// term sum, scale, shift, weight, rounding and saturation
module tecc_combine (
  input  logic                        clk,
  input  logic                        en,
  input  tecc_pkg::cfg_t              cfg,
  input  logic [tecc_pkg::Q_W-1:0]    q_a,
  input  logic [tecc_pkg::Q_W-1:0]    q_b,
  input  logic [tecc_pkg::Q_W-1:0]    q_r,
  output logic signed [tecc_pkg::COEF_W-1:0] coefficient
);
  import tecc_pkg::*;

  localparam logic signed [48:0] SAT_MAX = 49'sd8589934591;
  localparam logic signed [48:0] SAT_MIN = -49'sd8589934592;

  logic signed [37:0] s_nxt, s_r;
  logic signed [54:0] p_r;
  logic signed [46:0] w_nxt, w_r;
  logic [39:0]        pl_r;
  logic signed [41:0] ph_r;
  logic signed [64:0] prod;
  logic signed [48:0] rnd;
  logic signed [COEF_W-1:0] coef_nxt, coef_r;
  logic signed [54:0] pr;

  always_comb begin
    logic signed [37:0] ta, tb, tr;
    ta = -($signed({5'b0, q_a}) <<< 2);
    tb = -($signed({5'b0, q_b}) <<< 2);
    tr = $signed({5'b0, q_r});
    s_nxt = '0;
    if (cfg.electron_count != 2'd0) s_nxt = s_nxt + ta;
    if (cfg.electron_count[1]) s_nxt = s_nxt + tb + tr;
  end

  assign pr = p_r + 55'sd256;

  always_comb begin
    w_nxt = 47'(pr >>> 9);
    if (cfg.shift_enable) w_nxt = w_nxt + 47'(cfg.shift_offset);
  end

  assign prod = ($signed(65'(ph_r)) <<< 23) + $signed({25'b0, pl_r});
  assign rnd  = 49'((prod + 65'sd32768) >>> 16);

  always_comb begin
    if (rnd > SAT_MAX) begin
      coef_nxt = COEF_W'(SAT_MAX);
    end else if (rnd < SAT_MIN) begin
      coef_nxt = COEF_W'(SAT_MIN);
    end else begin
      coef_nxt = COEF_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_nxt;
      p_r    <= 55'(s_r) * 55'($signed({1'b0, cfg.scale_factor}));
      w_r    <= w_nxt;
      pl_r   <= w_r[22:0] * cfg.coupling_weight;
      ph_r   <= 42'($signed(w_r[46:23])) * 42'($signed({1'b0, cfg.coupling_weight}));
      coef_r <= coef_nxt;
    end
  end

  assign coefficient = coef_r;
endmodule

// ===== sv/two_electron_coulomb_coefficient_core.sv =====
// two-electron coulomb coefficient core, top level
// throughput: one sample point per cycle while the output is not blocked,
// set by the bit-per-stage divide and root pipeline
// a blocked output freezes the whole pipeline; no item is dropped or repeated
// synchronous active-low reset clears valid bits and loads register defaults
module two_electron_coulomb_coefficient_core (
  input  logic                        clk,
  input  logic                        rst_n,
  tecc_in_if.sink                     in_s,
  tecc_out_if.source                  out_s,
  input  logic                        cfg_we,
  input  logic [tecc_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [tecc_pkg::CFG_W-1:0]  cfg_wdata
);
  import tecc_pkg::*;

  cfg_t cfg_r;
  logic [LATENCY-1:0] vld_r;
  logic en;
  logic [D2_W-1:0] d2_a, d2_b, d2_r;
  logic [Q_W-1:0]  q_a, q_b, q_r;

  assign en = !vld_r[LATENCY-1] || out_s.ready;
  assign in_s.ready = en;
  assign out_s.valid = vld_r[LATENCY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.electron_count  <= 2'd2;
      cfg_r.scale_factor    <= 16'd60;
      cfg_r.shift_enable    <= 1'b1;
      cfg_r.shift_offset    <= -41'sd33447004;
      cfg_r.coupling_weight <= 17'd65536;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_ELECTRON_COUNT:  cfg_r.electron_count  <= cfg_wdata[1:0];
        REG_SCALE_FACTOR:    cfg_r.scale_factor    <= cfg_wdata[15:0];
        REG_SHIFT_ENABLE:    cfg_r.shift_enable    <= cfg_wdata[0];
        REG_SHIFT_OFFSET:    cfg_r.shift_offset    <= $signed(cfg_wdata);
        REG_COUPLING_WEIGHT: cfg_r.coupling_weight <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LATENCY-2:0], in_s.valid};
    end
  end

  tecc_sqdist u_sqdist (
    .clk  (clk),
    .en   (en),
    .e0_x (in_s.e0_x),
    .e0_y (in_s.e0_y),
    .e0_z (in_s.e0_z),
    .e1_x (in_s.e1_x),
    .e1_y (in_s.e1_y),
    .e1_z (in_s.e1_z),
    .d2_a (d2_a),
    .d2_b (d2_b),
    .d2_r (d2_r)
  );

  tecc_recip u_recip_a (.clk(clk), .en(en), .d2(d2_a), .q(q_a));
  tecc_recip u_recip_b (.clk(clk), .en(en), .d2(d2_b), .q(q_b));
  tecc_recip u_recip_r (.clk(clk), .en(en), .d2(d2_r), .q(q_r));

  tecc_combine u_combine (
    .clk         (clk),
    .en          (en),
    .cfg         (cfg_r),
    .q_a         (q_a),
    .q_b         (q_b),
    .q_r         (q_r),
    .coefficient (out_s.coefficient)
  );
endmodule
